>>> rtl/tapd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tapd_pkg;

  // Packet framing
  localparam int unsigned PktLen     = 6;
  localparam int unsigned StoreDepth = PktLen - 1;
  localparam logic [2:0]  LastPos    = 3'(PktLen - 1);
  localparam logic [2:0]  HeadPos    = 3'd0;
  localparam logic [2:0]  SyncPos    = 3'd3;
  localparam logic [7:0]  SyncMask   = 8'hC8;
  localparam logic [7:0]  HeadMatch  = 8'h80;
  localparam logic [7:0]  SyncMatch  = 8'hC0;

  // Width substituted for a width no capability accepts
  localparam logic [3:0]  WidthInvalid = 4'd5;

  localparam int unsigned InWidth  = 8;
  localparam int unsigned OutWidth = 48;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgExtended   = 3'd0,
    CfgFourButton = 3'd1,
    CfgMultifing  = 3'd2,
    CfgPalmDetect = 3'd3,
    CfgModelPen   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic extended;
    logic four_button;
    logic multifinger;
    logic palm_detect;
    logic model_pen;
  } caps_t;

  // Framer to decoder: the completed packet and its status
  typedef struct packed {
    logic                       done;
    logic                       resync;
    logic [7:0]                 last_byte;
    logic [StoreDepth-1:0][7:0] held;
  } packet_t;

  typedef struct packed {
    logic        resynced;
    logic        button_down;
    logic        button_up;
    logic        button_right;
    logic        button_left;
    logic        width_changed;
    logic [3:0]  finger_width;
    logic [7:0]  pressure;
    logic [12:0] y_position;
    logic [12:0] x_position;
  } result_t;

  // Does the capability set accept this raw width
  function automatic logic width_valid(caps_t caps, logic [3:0] w);
    logic ok;
    ok = 1'b0;
    if (caps.extended) begin
      case (w) inside
        [4'd0:4'd1]:  ok = caps.multifinger;
        4'd2:         ok = caps.model_pen;
        [4'd4:4'd15]: ok = caps.palm_detect;
        default:      ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tapd_frame.sv
`timescale 1ns / 1ps
`default_nettype none

module tapd_frame (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  output tapd_pkg::packet_t      pkt_o
);

  logic [2:0] count_q, count_d;
  logic       in_sync_q, in_sync_d;
  logic [tapd_pkg::StoreDepth-1:0][7:0] held_q;
  logic [2:0] pos;
  logic       fail;
  logic       last;

  // Position in the packet; out-of-range counts restart at the header
  always_comb begin
    pos = (count_q > tapd_pkg::LastPos) ? tapd_pkg::HeadPos : count_q;
  end

  // Framing checks on the header and the fourth byte
  assign fail = ((pos == tapd_pkg::HeadPos) &&
                 ((byte_i & tapd_pkg::SyncMask) != tapd_pkg::HeadMatch)) ||
                ((pos == tapd_pkg::SyncPos) &&
                 ((byte_i & tapd_pkg::SyncMask) != tapd_pkg::SyncMatch));
  assign last = !fail && (pos == tapd_pkg::LastPos);

  // Next count and sync state
  always_comb begin
    count_d   = count_q;
    in_sync_d = in_sync_q;
    if (step_i) begin
      if (fail) begin
        count_d   = tapd_pkg::HeadPos;
        in_sync_d = 1'b0;
      end else if (last) begin
        count_d   = tapd_pkg::HeadPos;
        in_sync_d = 1'b1;
      end else begin
        count_d = pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= tapd_pkg::HeadPos;
      in_sync_q <= 1'b1;
    end else begin
      count_q   <= count_d;
      in_sync_q <= in_sync_d;
    end
  end

  // Store bytes one to five of the packet
  always_ff @(posedge clk_i) begin
    if (step_i && !fail && !last) begin
      held_q[pos[2:0]] <= byte_i;
    end
  end

  always_comb begin
    pkt_o.done      = last;
    pkt_o.resync    = !in_sync_q;
    pkt_o.last_byte = byte_i;
    pkt_o.held      = held_q;
  end

endmodule

`default_nettype wire

>>> rtl/tapd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module tapd_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire tapd_pkg::caps_t   caps_i,
  input  wire tapd_pkg::packet_t pkt_i,
  output tapd_pkg::result_t      res_o
);

  logic [3:0] last_width_q, last_width_d;
  logic [7:0] b0, b1, b2, b3, b4, b5;
  logic [3:0] raw_width;
  logic [3:0] width;
  logic       four_btn;

  assign b0 = pkt_i.held[0];
  assign b1 = pkt_i.held[1];
  assign b2 = pkt_i.held[2];
  assign b3 = pkt_i.held[3];
  assign b4 = pkt_i.held[4];
  assign b5 = pkt_i.last_byte;

  assign raw_width = {b0[5:4], b0[2], b3[2]};
  assign four_btn  = caps_i.extended && caps_i.four_button;

  // Replace an unaccepted width while touching
  always_comb begin
    width = raw_width;
    if ((b2 != 8'd0) && !tapd_pkg::width_valid(caps_i, raw_width)) begin
      width = tapd_pkg::WidthInvalid;
    end
  end

  // Unpack the fields
  always_comb begin
    res_o.x_position    = {b3[4], b1[3:0], b4};
    res_o.y_position    = {b3[5], b1[7:4], b5};
    res_o.pressure      = b2;
    res_o.finger_width  = width;
    res_o.width_changed = (width != last_width_q);
    res_o.button_left   = b0[0];
    res_o.button_right  = b0[1];
    res_o.button_up     = four_btn && (b3[0] ^ b0[0]);
    res_o.button_down   = four_btn && (b3[1] ^ b0[1]);
    res_o.resynced      = pkt_i.resync;
  end

  // Track the last reported width
  always_comb begin
    last_width_d = last_width_q;
    if (step_i && pkt_i.done) begin
      last_width_d = width;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_width_q <= 4'd0;
    end else begin
      last_width_q <= last_width_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/touchpad_absolute_packet_decoder_core.sv
// The result of a sixth byte goes from the input register to the result register and
// is shown on m_axis from the result register, where it waits until its own transfer.
// Throughput: one byte per cycle while m_axis does not stall; the input register and
// the result register each take a new transfer in the cycle the next stage drains them.
// Bytes that complete no packet produce no result.
// Reset (rst_ni low, asynchronous) clears the byte count, sets sync, clears the
// last width and all capability registers, and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module touchpad_absolute_packet_decoder_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tapd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [0:0]                        cfg_wdata_i,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: [7:0] rx_byte
  input  wire logic [tapd_pkg::InWidth-1:0]      s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // tdata: [12:0] x_position, [25:13] y_position, [33:26] pressure,
  // [37:34] finger_width, [38] width_changed, [39] button_left,
  // [40] button_right, [41] button_up, [42] button_down, [43] resynced,
  // [47:44] zero
  output logic [tapd_pkg::OutWidth-1:0]          m_axis_tdata_o
);

  tapd_pkg::caps_t   caps_q, caps_d;
  tapd_pkg::packet_t pkt;
  tapd_pkg::result_t res;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  logic [tapd_pkg::OutWidth-1:0] out_data_q;
  logic       step;
  logic       s_fire;

  // Capability registers
  always_comb begin
    caps_d = caps_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tapd_pkg::CfgExtended:   caps_d.extended    = cfg_wdata_i[0];
        tapd_pkg::CfgFourButton: caps_d.four_button = cfg_wdata_i[0];
        tapd_pkg::CfgMultifing:  caps_d.multifinger = cfg_wdata_i[0];
        tapd_pkg::CfgPalmDetect: caps_d.palm_detect = cfg_wdata_i[0];
        tapd_pkg::CfgModelPen:   caps_d.model_pen   = cfg_wdata_i[0];
        default:                 caps_d = caps_q;
      endcase
    end
  end

  // Advance the held byte when the result slot is free or draining
  assign step   = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && pkt.done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q      <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      caps_q      <= caps_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input and result payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (step && pkt.done) begin
      out_data_q <= {{(tapd_pkg::OutWidth - $bits(tapd_pkg::result_t)){1'b0}}, res};
    end
  end

  tapd_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .pkt_o  (pkt)
  );

  tapd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .caps_i (caps_q),
    .pkt_i  (pkt),
    .res_o  (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/tapd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tapd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [tapd_pkg::OutWidth-1:0] m_axis_tdata_o
);

  logic [3:0] seen_width_q;
  logic       m_fire;

  assign m_fire = m_axis_tvalid_o && m_axis_tready_i;

  // Width of the last transferred result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_width_q <= 4'd0;
    end else if (m_fire) begin
      seen_width_q <= m_axis_tdata_o[37:34];
    end
  end

  // Held result stays put while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // No result is shown in the cycle after a reset edge
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid after reset");

  // An empty result slot never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result slot");

  // Width change flag agrees with the previous transferred width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire |-> (m_axis_tdata_o[38] == (m_axis_tdata_o[37:34] != seen_width_q)))
    else $error("width change flag inconsistent");

  // Padding bits are zero on a shown result while an input byte is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && s_axis_tvalid_i |-> (m_axis_tdata_o[47:44] == 4'd0))
    else $error("padding bits not zero");

endmodule

bind touchpad_absolute_packet_decoder_core tapd_checker u_tapd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tapd_pkg::*;

  // Cycles without any transfer before the run is declared hung
  localparam int StallLimit  = 4000;
  // Cycles to let the pipeline empty after the last expected result
  localparam int DrainCycles = 6;
  localparam int NumPhases   = 6;
  localparam int PhaseBytes  = 92;

  // Indexes past the last register; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareFirst = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSpareLast  = 3'd7;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i     = CfgExtended;
  logic [0:0]           cfg_wdata_i     = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InWidth-1:0]   s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutWidth-1:0]  m_axis_tdata_o;

  bit steady = 1'b0;
  int bytes_sent;

  touchpad_absolute_packet_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Packet framer and decoder model with its queue of pending reports
  class touch_report_board;
    caps_t      caps;
    logic [2:0] byte_count;
    logic [7:0] held [StoreDepth];
    bit         in_sync;
    logic [3:0] last_width;
    result_t    expected_reports [$];
    int         errors;

    function new();
      caps       = '0;
      byte_count = HeadPos;
      in_sync    = 1'b1;
      last_width = '0;
      errors     = 0;
      foreach (held[i]) held[i] = '0;
    endfunction

    function void set_cap(logic [CfgIdxW-1:0] idx, logic v);
      case (idx)
        CfgExtended:   caps.extended    = v;
        CfgFourButton: caps.four_button = v;
        CfgMultifing:  caps.multifinger = v;
        CfgPalmDetect: caps.palm_detect = v;
        CfgModelPen:   caps.model_pen   = v;
        default: ;
      endcase
    endfunction

    // Advance the framer by one byte; queue a report when a packet completes
    function void take_byte(logic [7:0] b);
      result_t    r;
      logic [3:0] w;
      logic       ok;
      if ((byte_count == HeadPos && (b & SyncMask) != HeadMatch) ||
          (byte_count == SyncPos && (b & SyncMask) != SyncMatch)) begin
        in_sync    = 1'b0;
        byte_count = HeadPos;
        return;
      end
      if (byte_count != LastPos) begin
        held[byte_count] = b;
        byte_count       = byte_count + 3'd1;
        return;
      end
      r.x_position   = {held[3][4], held[1][3:0], held[4]};
      r.y_position   = {held[3][5], held[1][7:4], b};
      r.pressure     = held[2];
      r.button_left  = held[0][0];
      r.button_right = held[0][1];
      r.button_up    = 1'b0;
      r.button_down  = 1'b0;
      if (caps.extended && caps.four_button) begin
        r.button_up   = held[3][0] ^ held[0][0];
        r.button_down = held[3][1] ^ held[0][1];
      end
      // Raw width, then replace it when a touch reports a width no capability allows
      w  = {held[0][5:4], held[0][2], held[3][2]};
      ok = caps.extended && ((w <= 4'd1 && caps.multifinger) ||
                             (w == 4'd2 && caps.model_pen) ||
                             (w >= 4'd4 && caps.palm_detect));
      if (r.pressure != 8'd0 && !ok) w = WidthInvalid;
      r.finger_width  = w;
      r.width_changed = (w != last_width);
      last_width      = w;
      r.resynced      = !in_sync;
      in_sync         = 1'b1;
      byte_count      = HeadPos;
      expected_reports.push_back(r);
    endfunction

    task report(string msg);
      $display("board: %s", msg);
      errors++;
    endtask

    task field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s: got %0d, want %0d", name, got, want));
    endtask

    task check_report(logic [OutWidth-1:0] data);
      result_t got;
      result_t want;
      if (expected_reports.size() == 0) begin
        report($sformatf("result %h with nothing pending", data));
        return;
      end
      want = expected_reports.pop_front();
      got  = data[$bits(result_t)-1:0];
      field("x_position",    got.x_position,    want.x_position);
      field("y_position",    got.y_position,    want.y_position);
      field("pressure",      got.pressure,      want.pressure);
      field("finger_width",  got.finger_width,  want.finger_width);
      field("width_changed", got.width_changed, want.width_changed);
      field("button_left",   got.button_left,   want.button_left);
      field("button_right",  got.button_right,  want.button_right);
      field("button_up",     got.button_up,     want.button_up);
      field("button_down",   got.button_down,   want.button_down);
      field("resynced",      got.resynced,      want.resynced);
      field("pad bits",      data[OutWidth-1:$bits(result_t)], 0);
    endtask
  endclass

  touch_report_board board;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] head_byte();
    logic [7:0] b;
    b = 8'($urandom);
    return (b & ~SyncMask) | HeadMatch;
  endfunction

  function automatic logic [7:0] sync_byte();
    logic [7:0] b;
    b = 8'($urandom);
    return (b & ~SyncMask) | SyncMatch;
  endfunction

  function automatic logic [7:0] bad_sync_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ((b & SyncMask) == SyncMatch) b = b ^ 8'h40;
    return b;
  endfunction

  // Observe both sides at the edge where transfers happen
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) board.take_byte(s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_report(m_axis_tdata_o);
  end

  // Result-side backpressure
  initial begin : result_stall
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Hang detection: cycles with no transfer on either side
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
  endtask

  // Well-formed packet with random content; torn ones end on a bad fourth byte
  task automatic push_packet(input bit torn);
    push_byte(head_byte());
    push_byte(8'($urandom));
    push_byte(($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom));
    if (torn) begin
      push_byte(bad_sync_byte());
      return;
    end
    push_byte(sync_byte());
    push_byte(8'($urandom));
    push_byte(8'($urandom));
  endtask

  // Hold the input idle until every pending report is out and the pipe is empty
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.set_cap(idx, v);
  endtask

  task automatic write_caps(input caps_t c);
    cfg_put(CfgExtended,   c.extended);
    cfg_put(CfgFourButton, c.four_button);
    cfg_put(CfgMultifing,  c.multifinger);
    cfg_put(CfgPalmDetect, c.palm_detect);
    cfg_put(CfgModelPen,   c.model_pen);
    cfg_put(CfgIdxW'($urandom_range(CfgSpareLast, CfgSpareFirst)), 1'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] opening [$];
    caps_t      c;
    int         r;
    board = new();
    // Minimal packet, bad header, all-ones packet after resync,
    // bad fourth byte, zero-pressure packet after resync
    opening = '{8'h80, 8'h00, 8'h00, 8'hC0, 8'h00, 8'h00,
                8'h88,
                8'hB7, 8'hFF, 8'hFF, 8'hF7, 8'hFF, 8'hFF,
                8'h80, 8'h12, 8'h34, 8'h80,
                8'h81, 8'h55, 8'h00, 8'hC5, 8'hAA, 8'h5A};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[i]) push_byte(opening[i]);

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      if (phase == 0) begin
        c = '1;
      end else if (phase == 1) begin
        c = '0;
      end else begin
        c = caps_t'($urandom);
        c.extended = ($urandom_range(0, 3) != 0);
      end
      write_caps(c);
      steady = (phase == 1) || ($urandom_range(0, 3) == 0);
      bytes_sent = 0;
      while (bytes_sent < PhaseBytes) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          push_packet(1'b0);
        end else if (r < 88) begin
          push_packet(1'b1);
        end else if (r < 94) begin
          push_byte(head_byte());
          repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
        end else begin
          push_byte(8'($urandom));
        end
      end
    end

    settle();
    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
